### design/dncf_pkg.sv
// Shared constants and helpers for the normal contact force unit.
package dncf_pkg;

    localparam int DEF_PARTICLE_COUNT = 1024;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int FORCE_W = 48;
    localparam int ACC_ROW_W = 3 * FORCE_W;
    localparam int IN_DATA_W  = 248;
    localparam int OUT_DATA_W = ACC_ROW_W;

    localparam logic [VAL_W-1:0] STIFF_RESET = 32'h0001_0000;
    localparam logic [VAL_W-1:0] DAMP_RESET  = 32'h0000_0000;

    localparam logic OP_CONTACT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic REG_STIFF = 1'b0;
    localparam logic REG_DAMP  = 1'b1;

    typedef logic signed [FORCE_W-1:0] t_force;

    function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] a);
        mag32 = a[VAL_W-1] ? (~a + 32'd1) : a;
    endfunction

    // Saturating add (or subtract, when sub is set) of two Q32.16 values; bit FORCE_W of the result flags a clamp.
    function automatic logic [FORCE_W:0] sat_add(input t_force a, input t_force b,
                                                 input logic sub);
        logic signed [FORCE_W:0] s;
        s = sub ? ({a[FORCE_W-1], a} - {b[FORCE_W-1], b})
                : ({a[FORCE_W-1], a} + {b[FORCE_W-1], b});
        if (s[FORCE_W] != s[FORCE_W-1]) begin
            sat_add = s[FORCE_W] ? {1'b1, 1'b1, {(FORCE_W-1){1'b0}}}
                                 : {1'b1, 1'b0, {(FORCE_W-1){1'b1}}};
        end else begin
            sat_add = {1'b0, s[FORCE_W-1:0]};
        end
    endfunction

endpackage

### design/dncf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dncf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/dem_normal_contact_force_unit.sv
// Top level of the linear spring-dashpot normal contact force unit.
//
// The unit takes one beat at a time on the slave stream. A contact beat forms
// the unit normal from the contact vector (bit-serial square root, then one
// bit-serial division per component), projects the relative velocity on it,
// builds the spring-dashpot scalar and scales the normal by it, all on one
// shared 32x32 multiplier used in halves for each product (ST_M1 to ST_M3). The
// force is returned and also added to the source particle's accumulator and
// subtracted from the destination's, by read-modify-write on one accumulator
// RAM. Most of a contact beat's time goes to the bit-serial divider, run once
// per component, and to the square root; a contact with a zero vector skips
// straight to the accumulator update with zero force. A stalled output holds
// the sequencer back only while the previous result still waits. The
// next beat is taken once the previous result sits in the output register,
// so the output may stall without holding up the input by more than one
// result. After reset the accumulator RAM is cleared one entry a cycle; no
// beat is taken during that pass, while APB writes are always taken. Indices
// at or above PARTICLE_COUNT leave the accumulators alone, and a read of such
// an index returns zero.
module dem_normal_contact_force_unit #(
    parameter int PARTICLE_COUNT = dncf_pkg::DEF_PARTICLE_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // From bit 0: src_index[9:0], dst_index[19:10], contact_x[51:20],
    // contact_y[83:52], contact_z[115:84], overlap[147:116], rel_vel_x[179:148],
    // rel_vel_y[211:180], rel_vel_z[243:212], zero fill.
    input  logic [dncf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation.
    input  logic                            s_axis_tuser,
    // Master stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // From bit 0: force_x[47:0], force_y[95:48], force_z[143:96].
    output logic [dncf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // saturated.
    output logic                            m_axis_tuser,
    // APB configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import dncf_pkg::*;

    localparam int AW = $clog2(PARTICLE_COUNT);
    localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_CLR      = 5'd1;
    localparam logic [4:0] ST_SQ       = 5'd2;
    localparam logic [4:0] ST_M1       = 5'd3;
    localparam logic [4:0] ST_M2       = 5'd4;
    localparam logic [4:0] ST_M3       = 5'd5;
    localparam logic [4:0] ST_SQ_ACC   = 5'd6;
    localparam logic [4:0] ST_SQRT     = 5'd7;
    localparam logic [4:0] ST_DIVCHK   = 5'd8;
    localparam logic [4:0] ST_DIV_INIT = 5'd9;
    localparam logic [4:0] ST_DIV      = 5'd10;
    localparam logic [4:0] ST_DIV_DONE = 5'd11;
    localparam logic [4:0] ST_DOT_ACC  = 5'd12;
    localparam logic [4:0] ST_VN       = 5'd13;
    localparam logic [4:0] ST_T1       = 5'd14;
    localparam logic [4:0] ST_T2       = 5'd15;
    localparam logic [4:0] ST_F        = 5'd16;
    localparam logic [4:0] ST_F_DONE   = 5'd17;
    localparam logic [4:0] ST_ACC      = 5'd18;
    localparam logic [4:0] ST_SRC_UPD  = 5'd19;
    localparam logic [4:0] ST_DST      = 5'd20;
    localparam logic [4:0] ST_DST_UPD  = 5'd21;
    localparam logic [4:0] ST_RD       = 5'd22;
    localparam logic [4:0] ST_RD_WAIT  = 5'd23;
    localparam logic [4:0] ST_OUT      = 5'd24;

    // Configuration registers.
    logic [31:0] r_stiff, r_damp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DAMP) ? r_damp : r_stiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFF_RESET;
            r_damp  <= DAMP_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_STIFF) begin
                r_stiff <= pwdata;
            end else begin
                r_damp <= pwdata;
            end
        end
    end

    // Sequencer state and operands.
    logic [4:0]           r_state, r_ret;
    logic                 r_op;
    logic [IDX_W-1:0]     r_src, r_dst;
    logic [VAL_W-1:0]     r_c [3];
    logic [VAL_W-1:0]     r_v [3];
    logic [VAL_W-1:0]     r_ov;
    logic [1:0]           r_k;
    logic [5:0]           r_cnt;
    logic [63:0]          r_sq, r_x, r_root;
    logic [31:0]          r_len, r_rem;
    logic [47:0]          r_dvd;
    logic [16:0]          r_nmag [3];
    logic                 r_nneg [3];
    logic signed [51:0]   r_dot, r_s;
    logic [63:0]          r_ma, r_pp;
    logic [31:0]          r_mb;
    logic [95:0]          r_prod;
    logic [34:0]          r_vnmag;
    logic                 r_vnneg;
    t_force               r_f [3];
    logic                 r_sat;
    logic [AW-1:0]        r_clr;

    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_sat, r_out_valid;

    // Accumulator RAM access.
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr, src_addr, dst_addr;
    logic [ACC_ROW_W-1:0] ram_wdata, ram_rdata;
    logic                 src_ok, dst_ok;
    logic [FORCE_W:0]     n_ax, n_ay, n_az;
    logic                 upd_sub;

    assign src_ok   = IW'(r_src) < IW'(PARTICLE_COUNT);
    assign dst_ok   = IW'(r_dst) < IW'(PARTICLE_COUNT);
    assign src_addr = AW'(r_src);
    assign dst_addr = AW'(r_dst);
    assign upd_sub  = (r_state == ST_DST_UPD);

    assign n_ax = sat_add(t_force'(ram_rdata[47:0]),   r_f[0], upd_sub);
    assign n_ay = sat_add(t_force'(ram_rdata[95:48]),  r_f[1], upd_sub);
    assign n_az = sat_add(t_force'(ram_rdata[143:96]), r_f[2], upd_sub);

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = src_addr;
        ram_raddr = src_addr;
        ram_wdata = {n_az[FORCE_W-1:0], n_ay[FORCE_W-1:0], n_ax[FORCE_W-1:0]};
        case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_ACC, ST_RD: begin
                ram_re = 1'b1;
            end
            ST_SRC_UPD: begin
                ram_we = 1'b1;
            end
            ST_DST: begin
                ram_re    = 1'b1;
                ram_raddr = dst_addr;
            end
            ST_DST_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = dst_addr;
            end
            ST_RD_WAIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    dncf_ram #(
        .WIDTH (ACC_ROW_W),
        .DEPTH (PARTICLE_COUNT)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Combinational helpers for the iterative units.
    logic [63:0] n_bit, n_trial;
    logic [32:0] n_rem_sh;
    logic        n_qbit;
    logic [63:0] n_mq;
    logic        n_fneg;
    logic [51:0] n_smag;
    logic [51:0] n_dotmag;
    logic [48:0] n_term;

    assign n_bit    = 64'd1 << {r_cnt[4:0], 1'b0};
    assign n_trial  = r_root + n_bit;
    assign n_rem_sh = {r_rem, r_dvd[47]};
    assign n_qbit   = n_rem_sh >= {1'b0, r_len};
    assign n_mq     = r_prod[79:16];
    assign n_fneg   = r_s[51] ^ r_nneg[r_k];
    assign n_smag   = r_s[51] ? 52'(-r_s) : 52'(r_s);
    assign n_dotmag = r_dot[51] ? 52'(-r_dot) : 52'(r_dot);
    assign n_term   = r_prod[48:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result handed over in the same cycle keeps the register full.
            if (r_out_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(PARTICLE_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op   <= s_axis_tuser;
                        r_src  <= s_axis_tdata[9:0];
                        r_dst  <= s_axis_tdata[19:10];
                        r_c[0] <= s_axis_tdata[51:20];
                        r_c[1] <= s_axis_tdata[83:52];
                        r_c[2] <= s_axis_tdata[115:84];
                        r_ov   <= s_axis_tdata[147:116];
                        r_v[0] <= s_axis_tdata[179:148];
                        r_v[1] <= s_axis_tdata[211:180];
                        r_v[2] <= s_axis_tdata[243:212];
                        r_k    <= 2'd0;
                        r_sq   <= '0;
                        r_dot  <= '0;
                        r_sat  <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_f[i] <= '0;
                        end
                        r_state <= (s_axis_tuser == OP_READ) ? ST_RD : ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_ma    <= 64'(mag32(r_c[r_k]));
                    r_mb    <= mag32(r_c[r_k]);
                    r_ret   <= ST_SQ_ACC;
                    r_state <= ST_M1;
                end
                // Shared multiplier: low half, then high half, then combine.
                ST_M1: begin
                    r_pp    <= r_ma[31:0] * r_mb;
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_prod  <= {32'd0, r_pp};
                    r_pp    <= r_ma[63:32] * r_mb;
                    r_state <= ST_M3;
                end
                ST_M3: begin
                    r_prod  <= r_prod + {r_pp, 32'd0};
                    r_state <= r_ret;
                end
                ST_SQ_ACC: begin
                    r_sq <= r_sq + r_prod[63:0];
                    if (r_k == 2'd2) begin
                        r_x     <= r_sq + r_prod[63:0];
                        r_root  <= '0;
                        r_cnt   <= 6'd31;
                        r_state <= ST_SQRT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQRT: begin
                    if (r_x >= n_trial) begin
                        r_x    <= r_x - n_trial;
                        r_root <= (r_root >> 1) + n_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_DIVCHK;
                    end
                end
                ST_DIVCHK: begin
                    r_len <= r_root[31:0];
                    r_k   <= 2'd0;
                    // A zero contact vector gives zero force, still accumulated.
                    r_state <= (r_root[31:0] == 32'd0) ? ST_ACC : ST_DIV_INIT;
                end
                ST_DIV_INIT: begin
                    r_rem   <= '0;
                    r_dvd   <= {mag32(r_c[r_k]), 16'd0};
                    r_cnt   <= 6'd47;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_qbit ? 32'(n_rem_sh - {1'b0, r_len}) : n_rem_sh[31:0];
                    r_dvd <= {r_dvd[46:0], n_qbit};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_DIV_DONE;
                    end
                end
                ST_DIV_DONE: begin
                    r_nmag[r_k] <= r_dvd[16:0];
                    r_nneg[r_k] <= r_c[r_k][31];
                    r_ma        <= 64'(r_dvd[16:0]);
                    r_mb        <= mag32(r_v[r_k]);
                    r_ret       <= ST_DOT_ACC;
                    r_state     <= ST_M1;
                end
                ST_DOT_ACC: begin
                    if (r_nneg[r_k] ^ r_v[r_k][31]) begin
                        r_dot <= r_dot - 52'(n_term);
                    end else begin
                        r_dot <= r_dot + 52'(n_term);
                    end
                    if (r_k == 2'd2) begin
                        r_state <= ST_VN;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_DIV_INIT;
                    end
                end
                ST_VN: begin
                    r_vnmag <= n_dotmag[50:16];
                    r_vnneg <= r_dot[51];
                    r_ma    <= 64'(mag32(r_ov));
                    r_mb    <= r_stiff;
                    r_ret   <= ST_T1;
                    r_state <= ST_M1;
                end
                ST_T1: begin
                    // Spring term enters with a negative sign.
                    r_s     <= r_ov[31] ? $signed(52'(r_prod[79:16]))
                                        : -$signed(52'(r_prod[79:16]));
                    r_ma    <= 64'(r_vnmag);
                    r_mb    <= r_damp;
                    r_ret   <= ST_T2;
                    r_state <= ST_M1;
                end
                ST_T2: begin
                    if (r_vnneg) begin
                        r_s <= r_s - $signed(52'(r_prod[79:16]));
                    end else begin
                        r_s <= r_s + $signed(52'(r_prod[79:16]));
                    end
                    r_k     <= 2'd0;
                    r_state <= ST_F;
                end
                ST_F: begin
                    r_ma    <= 64'(n_smag);
                    r_mb    <= 32'(r_nmag[r_k]);
                    r_ret   <= ST_F_DONE;
                    r_state <= ST_M1;
                end
                ST_F_DONE: begin
                    if (!n_fneg && (n_mq > 64'h7FFF_FFFF_FFFF)) begin
                        r_f[r_k] <= {1'b0, {(FORCE_W-1){1'b1}}};
                        r_sat    <= 1'b1;
                    end else if (n_fneg && (n_mq > 64'h8000_0000_0000)) begin
                        r_f[r_k] <= {1'b1, {(FORCE_W-1){1'b0}}};
                        r_sat    <= 1'b1;
                    end else if (n_fneg) begin
                        r_f[r_k] <= t_force'(-n_mq[47:0]);
                    end else begin
                        r_f[r_k] <= t_force'(n_mq[47:0]);
                    end
                    if (r_k == 2'd2) begin
                        r_state <= ST_ACC;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_F;
                    end
                end
                ST_ACC: begin
                    r_state <= src_ok ? ST_SRC_UPD : ST_DST;
                end
                ST_SRC_UPD: begin
                    r_sat   <= r_sat | n_ax[FORCE_W] | n_ay[FORCE_W] | n_az[FORCE_W];
                    r_state <= ST_DST;
                end
                ST_DST: begin
                    r_state <= dst_ok ? ST_DST_UPD : ST_OUT;
                end
                ST_DST_UPD: begin
                    r_sat   <= r_sat | n_ax[FORCE_W] | n_ay[FORCE_W] | n_az[FORCE_W];
                    r_state <= ST_OUT;
                end
                ST_RD: begin
                    r_state <= src_ok ? ST_RD_WAIT : ST_OUT;
                end
                ST_RD_WAIT: begin
                    r_f[0]  <= t_force'(ram_rdata[47:0]);
                    r_f[1]  <= t_force'(ram_rdata[95:48]);
                    r_f[2]  <= t_force'(ram_rdata[143:96]);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload, loaded as the sequencer hands over.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {r_f[2], r_f[1], r_f[0]};
            r_out_sat  <= (r_op == OP_CONTACT) ? r_sat : 1'b0;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

endmodule
